[rtl/tlpa_pkg.sv]
// ----------------------------------------------------------------------------
// tlpa_pkg
// Shared constants, widths and the sequencer state type of the two-level
// page allocator.
// ----------------------------------------------------------------------------
package tlpa_pkg;

    // address split
    localparam int DIR_INDEX_BITS   = 4;
    localparam int TABLE_INDEX_BITS = 4;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int FRAME_COUNT      = 64;

    // field widths
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 20;
    localparam int BYTES_W = 21;

    // derived sizes
    localparam int VPN_W      = DIR_INDEX_BITS + TABLE_INDEX_BITS;
    localparam int VPAGES     = 1 << VPN_W;
    localparam int DIR_SLOTS  = 1 << DIR_INDEX_BITS;
    localparam int TABLE_SLOTS = 1 << TABLE_INDEX_BITS;
    localparam int FRAME_W    = $clog2(FRAME_COUNT);
    localparam int PG_BYTES   = 1 << PAGE_OFFSET_BITS;
    localparam int DIR_FRAMES = (DIR_SLOTS * 4 + PG_BYTES - 1) >> PAGE_OFFSET_BITS;
    localparam int TIDX_W     = FRAME_W + TABLE_INDEX_BITS;
    localparam int TDEPTH     = 1 << TIDX_W;
    localparam int ENTRY_W    = FRAME_W + 1;
    localparam int CNT_W      = BYTES_W - PAGE_OFFSET_BITS + 1;
    localparam int PAGE_W     = VPN_W + 1;

    // stream widths
    localparam int S_DATA_W = ((ADDR_W + BYTES_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((1 + ADDR_W + 7) / 8) * 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XLATE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DFIND,
        S_TFIND,
        S_CLEAR,
        S_LOOK,
        S_CHECK,
        S_FREE_PAGE,
        S_FREE_CHECK,
        S_XLATE,
        S_XLATE_CHECK,
        S_DONE
    } state_t;

endpackage

[rtl/two_level_page_allocator_mmu.sv]
// ----------------------------------------------------------------------------
// two_level_page_allocator_mmu
// Page allocator with virtual-page and frame bitmaps, a page directory and
// page tables held in one table memory, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_axis channel: tuser carries the kind (allocate,
//   free, translate), tdata the byte address and byte count. Each request
//   gives exactly one response on m_axis: tdata holds status and address.
//   One request is worked at a time; s_axis_tready is high only while idle.
//   Allocate scans the virtual bitmap one page a cycle, then for each
//   page scans the frame bitmap from frame 0, one frame a cycle, for a
//   data frame and, if the directory slot is empty, a table frame that is
//   then cleared slot by slot; the table slot is then read through the
//   registered read port of the table memory and checked. At most 63
//   frames can be handed out. Free reads the table slot of each page whose
//   directory slot is valid; translate reads one table slot.
//   The response sits in an output register; a new request is taken while it
//   waits, and the block stalls at the end of that request until the
//   receiver takes the earlier response.
//   Reset clears both bitmaps (page zero and the directory frames stay
//   reserved) and the directory; table memory needs no clearing pass since
//   a table is cleared when its frame becomes a table.
// ----------------------------------------------------------------------------
module two_level_page_allocator_mmu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // address [19:0], byte_count [40:20], zero pad
    input  logic [tlpa_pkg::S_DATA_W-1:0] s_axis_tdata,
    // kind [1:0]
    input  logic [tlpa_pkg::KIND_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status [0], result_address [20:1], zero pad
    output logic [tlpa_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int PO  = tlpa_pkg::PAGE_OFFSET_BITS;
    localparam int TB  = tlpa_pkg::TABLE_INDEX_BITS;
    localparam int DB  = tlpa_pkg::DIR_INDEX_BITS;
    localparam int VW  = tlpa_pkg::VPN_W;
    localparam int FW  = tlpa_pkg::FRAME_W;
    localparam int NW  = tlpa_pkg::CNT_W;
    localparam int PW  = tlpa_pkg::PAGE_W;
    localparam int AW  = tlpa_pkg::ADDR_W;
    localparam int BW  = tlpa_pkg::BYTES_W;
    localparam int EW  = tlpa_pkg::ENTRY_W;
    localparam int IW  = tlpa_pkg::TIDX_W;
    localparam int MW  = tlpa_pkg::M_DATA_W;
    localparam int NF  = tlpa_pkg::FRAME_COUNT;
    localparam int NV  = tlpa_pkg::VPAGES;
    localparam int ND  = tlpa_pkg::DIR_SLOTS;
    localparam logic [NF-1:0] FRAME_RESET = NF'((1 << tlpa_pkg::DIR_FRAMES) - 1);

    tlpa_pkg::state_t state_reg, state_next;

    // request registers
    logic [tlpa_pkg::KIND_W-1:0] kind_reg;
    logic [AW-1:0]               address_reg;
    logic                        bytes_zero_reg;
    logic [NW-1:0]               need_reg;

    // sequencer datapath
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] run_reg;
    logic [VW-1:0] start_reg;
    logic [PW-1:0] page_reg;
    logic [FW-1:0] fcnt_reg;
    logic [FW-1:0] df_reg;
    logic [FW-1:0] tf_reg;
    logic [TB-1:0] sweep_reg;

    // bitmaps and directory
    logic [NV-1:0] vp_used_reg;
    logic [NF-1:0] frame_used_reg;
    logic [ND-1:0] dir_valid_reg;
    logic [FW-1:0] dir_frame_reg [ND];

    // result
    logic          res_status_reg;
    logic [AW-1:0] res_addr_reg;
    logic          out_valid_reg;
    logic          out_status_reg;
    logic [AW-1:0] out_addr_reg;

    // table memory
    logic [EW-1:0] table_mem [tlpa_pkg::TDEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [IW-1:0] rd_addr;

    // decoded fields
    logic [AW-1:0]              in_address;
    logic [BW-1:0]              in_bytes;
    logic [DB-1:0]              dir_idx;
    logic [TB-1:0]              slot_idx;
    logic [VW-1:0]              scan_vp;
    logic [NW-1:0]              run_inc;
    logic                       scan_free;
    logic                       scan_hit;
    logic                       scan_end;
    logic                       frame_free;
    logic                       frame_end;
    logic                       rd_valid;
    logic [FW-1:0]              rd_frame;
    logic                       out_free;

    assign in_address = s_axis_tdata[AW-1:0];
    assign in_bytes   = s_axis_tdata[AW+BW-1:AW];
    assign dir_idx    = page_reg[VW-1:TB];
    assign slot_idx   = page_reg[TB-1:0];
    assign rd_addr    = {dir_frame_reg[dir_idx], slot_idx};
    assign scan_vp    = cnt_reg[VW-1:0];
    assign scan_free  = !vp_used_reg[scan_vp];
    assign run_inc    = run_reg + NW'(1);
    assign scan_hit   = scan_free && (run_inc == need_reg);
    assign scan_end   = (cnt_reg == NW'(NV - 1));
    assign frame_free = !frame_used_reg[fcnt_reg];
    assign frame_end  = (fcnt_reg == FW'(NF - 1));
    assign rd_valid   = rd_data_reg[EW-1];
    assign rd_frame   = rd_data_reg[FW-1:0];
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == tlpa_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = MW'({out_addr_reg, out_status_reg});

    // next state and table memory port control
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = rd_addr;
        wr_data    = '0;
        unique case (state_reg)
            tlpa_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = tlpa_pkg::S_DISPATCH;
            end
            tlpa_pkg::S_DISPATCH:
            begin
                priority if (kind_reg == tlpa_pkg::KIND_ALLOC)
                    state_next = bytes_zero_reg ? tlpa_pkg::S_DONE : tlpa_pkg::S_SCAN;
                else if (kind_reg == tlpa_pkg::KIND_FREE)
                    state_next = (bytes_zero_reg || address_reg == '0) ?
                                 tlpa_pkg::S_DONE : tlpa_pkg::S_FREE_PAGE;
                else if (kind_reg == tlpa_pkg::KIND_XLATE)
                    state_next = tlpa_pkg::S_XLATE;
                else
                    state_next = tlpa_pkg::S_DONE;
            end
            tlpa_pkg::S_SCAN:
            begin
                if (scan_hit)
                    state_next = tlpa_pkg::S_DFIND;
                else if (scan_end)
                    state_next = tlpa_pkg::S_DONE;
            end
            tlpa_pkg::S_DFIND:
            begin
                if (frame_free)
                    state_next = dir_valid_reg[dir_idx] ? tlpa_pkg::S_LOOK : tlpa_pkg::S_TFIND;
                else if (frame_end)
                    state_next = tlpa_pkg::S_DONE;
            end
            tlpa_pkg::S_TFIND:
            begin
                if (frame_free)
                    state_next = tlpa_pkg::S_CLEAR;
                else if (frame_end)
                    state_next = tlpa_pkg::S_DONE;
            end
            tlpa_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = {tf_reg, sweep_reg};
                if (sweep_reg == '1)
                    state_next = tlpa_pkg::S_LOOK;
            end
            tlpa_pkg::S_LOOK:
            begin
                rd_en      = 1'b1;
                state_next = tlpa_pkg::S_CHECK;
            end
            tlpa_pkg::S_CHECK:
            begin
                if (rd_valid)
                    state_next = tlpa_pkg::S_DONE;
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, df_reg};
                    state_next = (cnt_reg + NW'(1) == need_reg) ?
                                 tlpa_pkg::S_DONE : tlpa_pkg::S_DFIND;
                end
            end
            tlpa_pkg::S_FREE_PAGE:
            begin
                priority if (cnt_reg == need_reg || page_reg[VW])
                    state_next = tlpa_pkg::S_DONE;
                else if (dir_valid_reg[dir_idx])
                begin
                    rd_en      = 1'b1;
                    state_next = tlpa_pkg::S_FREE_CHECK;
                end
            end
            tlpa_pkg::S_FREE_CHECK:
            begin
                wr_en      = rd_valid;
                state_next = tlpa_pkg::S_FREE_PAGE;
            end
            tlpa_pkg::S_XLATE:
            begin
                if (page_reg[VW] || !dir_valid_reg[dir_idx])
                    state_next = tlpa_pkg::S_DONE;
                else
                begin
                    rd_en      = 1'b1;
                    state_next = tlpa_pkg::S_XLATE_CHECK;
                end
            end
            tlpa_pkg::S_XLATE_CHECK:
            begin
                state_next = tlpa_pkg::S_DONE;
            end
            tlpa_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = tlpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tlpa_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tlpa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

    // bitmaps, directory and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_used_reg    <= NV'(1);
            frame_used_reg <= FRAME_RESET;
            dir_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // response loaded at the end of a request, cleared on transfer
            if (state_reg == tlpa_pkg::S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                tlpa_pkg::S_DFIND:
                begin
                    if (frame_free)
                        frame_used_reg[fcnt_reg] <= 1'b1;
                end
                tlpa_pkg::S_TFIND:
                begin
                    // table frame taken, or data frame handed back on exhaustion
                    if (frame_free)
                    begin
                        frame_used_reg[fcnt_reg] <= 1'b1;
                        dir_valid_reg[dir_idx]   <= 1'b1;
                    end
                    else if (frame_end)
                        frame_used_reg[df_reg] <= 1'b0;
                end
                tlpa_pkg::S_CHECK:
                begin
                    if (rd_valid)
                        frame_used_reg[df_reg] <= 1'b0;
                    else
                        vp_used_reg[page_reg[VW-1:0]] <= 1'b1;
                end
                tlpa_pkg::S_FREE_CHECK:
                begin
                    if (rd_valid)
                    begin
                        vp_used_reg[page_reg[VW-1:0]] <= 1'b0;
                        frame_used_reg[rd_frame]      <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tlpa_pkg::S_IDLE:
            begin
                // latch request and round bytes up to pages
                kind_reg       <= s_axis_tuser;
                address_reg    <= in_address;
                bytes_zero_reg <= (in_bytes == '0);
                need_reg       <= NW'(in_bytes >> PO) + NW'(|in_bytes[PO-1:0]);
                page_reg       <= PW'(in_address >> PO);
                cnt_reg        <= '0;
                run_reg        <= '0;
                res_status_reg <= tlpa_pkg::STATUS_FAIL;
                res_addr_reg   <= '0;
            end
            tlpa_pkg::S_DISPATCH:
            begin
                if (kind_reg == tlpa_pkg::KIND_FREE)
                    res_status_reg <= tlpa_pkg::STATUS_OK;
            end
            tlpa_pkg::S_SCAN:
            begin
                // first-fit run search, one virtual page a cycle
                if (scan_free)
                begin
                    run_reg <= run_inc;
                    if (run_reg == '0)
                        start_reg <= scan_vp;
                end
                else
                    run_reg <= '0;
                if (scan_hit)
                begin
                    cnt_reg  <= '0;
                    fcnt_reg <= '0;
                    page_reg <= (run_reg == '0) ? PW'(scan_vp) : PW'(start_reg);
                end
                else
                    cnt_reg <= cnt_reg + NW'(1);
            end
            tlpa_pkg::S_DFIND:
            begin
                if (frame_free)
                begin
                    df_reg   <= fcnt_reg;
                    fcnt_reg <= '0;
                end
                else
                    fcnt_reg <= fcnt_reg + FW'(1);
            end
            tlpa_pkg::S_TFIND:
            begin
                if (frame_free)
                begin
                    tf_reg                 <= fcnt_reg;
                    dir_frame_reg[dir_idx] <= fcnt_reg;
                    sweep_reg              <= '0;
                end
                else
                    fcnt_reg <= fcnt_reg + FW'(1);
            end
            tlpa_pkg::S_CLEAR:
            begin
                sweep_reg <= sweep_reg + TB'(1);
            end
            tlpa_pkg::S_CHECK:
            begin
                if (!rd_valid)
                begin
                    cnt_reg  <= cnt_reg + NW'(1);
                    page_reg <= page_reg + PW'(1);
                    fcnt_reg <= '0;
                    if (cnt_reg + NW'(1) == need_reg)
                    begin
                        res_status_reg <= tlpa_pkg::STATUS_OK;
                        res_addr_reg   <= AW'({start_reg, PO'(0)});
                    end
                end
            end
            tlpa_pkg::S_FREE_PAGE:
            begin
                if (!(cnt_reg == need_reg || page_reg[VW]) && !dir_valid_reg[dir_idx])
                begin
                    cnt_reg  <= cnt_reg + NW'(1);
                    page_reg <= page_reg + PW'(1);
                end
            end
            tlpa_pkg::S_FREE_CHECK:
            begin
                cnt_reg  <= cnt_reg + NW'(1);
                page_reg <= page_reg + PW'(1);
            end
            tlpa_pkg::S_XLATE_CHECK:
            begin
                if (rd_valid)
                begin
                    res_status_reg <= tlpa_pkg::STATUS_OK;
                    res_addr_reg   <= AW'({rd_frame, address_reg[PO-1:0]});
                end
            end
            tlpa_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_addr_reg   <= res_addr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/tlpa_checker.sv]
// ----------------------------------------------------------------------------
// tlpa_checker
// Port-level checks on the allocator's request and response channels.
// ----------------------------------------------------------------------------
module tlpa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [tlpa_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // response held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("response dropped before transfer");

    // response leaves only through a transfer
    a_out_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("response withdrawn without transfer");

    // one request at a time: busy right after a transfer in
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // pad bits of the response stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[tlpa_pkg::M_DATA_W-1:tlpa_pkg::ADDR_W+1] == '0)
        else $error("response pad bits set");

endmodule

bind two_level_page_allocator_mmu tlpa_checker u_tlpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level page allocator: directed and random
// allocate, free, translate and unused-kind requests on the request stream, a
// behavioral model of bitmaps, directory and tables predicts each response,
// compared field by field on the response stream under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = tlpa_pkg::ADDR_W;
    localparam int BW = tlpa_pkg::BYTES_W;
    localparam int KW = tlpa_pkg::KIND_W;
    localparam int SW = tlpa_pkg::S_DATA_W;
    localparam int MW = tlpa_pkg::M_DATA_W;

    typedef struct packed {
        logic          status;
        logic [AW-1:0] address;
    } response_t;

    // model of the allocator state and queue of predicted responses
    class page_scoreboard;
        bit        page_used [tlpa_pkg::VPAGES];
        bit        frame_used [tlpa_pkg::FRAME_COUNT];
        bit        dir_valid [tlpa_pkg::DIR_SLOTS];
        int        dir_frame [tlpa_pkg::DIR_SLOTS];
        bit        slot_valid [tlpa_pkg::FRAME_COUNT*tlpa_pkg::TABLE_SLOTS];
        int        slot_frame [tlpa_pkg::FRAME_COUNT*tlpa_pkg::TABLE_SLOTS];
        response_t pending [$];
        int        errors;

        function void clear_state();
            foreach (page_used[i])
                page_used[i] = 0;
            page_used[0] = 1;
            foreach (frame_used[i])
                frame_used[i] = (i < tlpa_pkg::DIR_FRAMES);
            foreach (dir_valid[i])
            begin
                dir_valid[i] = 0;
                dir_frame[i] = 0;
            end
            foreach (slot_valid[i])
            begin
                slot_valid[i] = 0;
                slot_frame[i] = 0;
            end
        endfunction

        function int grab_frame();
            for (int f = 0; f < tlpa_pkg::FRAME_COUNT; f++)
                if (!frame_used[f])
                begin
                    frame_used[f] = 1;
                    return f;
                end
            return -1;
        endfunction

        function int slot_index(int vp);
            return dir_frame[vp >> tlpa_pkg::TABLE_INDEX_BITS] * tlpa_pkg::TABLE_SLOTS
                   + (vp % tlpa_pkg::TABLE_SLOTS);
        endfunction

        function response_t allocate(longint bytes);
            response_t r;
            longint need, run;
            int start, df, tf, s, pg, d;
            r = '{tlpa_pkg::STATUS_FAIL, '0};
            if (bytes == 0)
                return r;
            need = (bytes + tlpa_pkg::PG_BYTES - 1) >> tlpa_pkg::PAGE_OFFSET_BITS;
            run = 0;
            start = -1;
            for (int vp = 0; vp < tlpa_pkg::VPAGES; vp++)
            begin
                if (page_used[vp])
                begin
                    run = 0;
                    continue;
                end
                if (run == 0)
                    start = vp;
                run++;
                if (run == need)
                    break;
            end
            if (run != need)
                return r;
            for (int i = 0; i < need; i++)
            begin
                pg = start + i;
                d = pg >> tlpa_pkg::TABLE_INDEX_BITS;
                df = grab_frame();
                if (df < 0)
                    return r;
                if (!dir_valid[d])
                begin
                    tf = grab_frame();
                    if (tf < 0)
                    begin
                        frame_used[df] = 0;
                        return r;
                    end
                    for (int k = 0; k < tlpa_pkg::TABLE_SLOTS; k++)
                    begin
                        slot_valid[tf*tlpa_pkg::TABLE_SLOTS+k] = 0;
                        slot_frame[tf*tlpa_pkg::TABLE_SLOTS+k] = 0;
                    end
                    dir_frame[d] = tf;
                    dir_valid[d] = 1;
                end
                s = slot_index(pg);
                if (slot_valid[s])
                begin
                    frame_used[df] = 0;
                    return r;
                end
                slot_frame[s] = df;
                slot_valid[s] = 1;
                page_used[pg] = 1;
            end
            r.status = tlpa_pkg::STATUS_OK;
            r.address = AW'(start << tlpa_pkg::PAGE_OFFSET_BITS);
            return r;
        endfunction

        function void release_range(longint addr, longint bytes);
            longint pages, vp;
            int s;
            if (addr == 0 || bytes == 0)
                return;
            pages = (bytes + tlpa_pkg::PG_BYTES - 1) >> tlpa_pkg::PAGE_OFFSET_BITS;
            for (longint i = 0; i < pages; i++)
            begin
                vp = (addr >> tlpa_pkg::PAGE_OFFSET_BITS) + i;
                if (vp >= tlpa_pkg::VPAGES)
                    break;
                if (!dir_valid[vp >> tlpa_pkg::TABLE_INDEX_BITS])
                    continue;
                s = slot_index(int'(vp));
                if (!slot_valid[s])
                    continue;
                page_used[vp] = 0;
                frame_used[slot_frame[s]] = 0;
                slot_valid[s] = 0;
                slot_frame[s] = 0;
            end
        endfunction

        function response_t translate(longint addr);
            response_t r;
            longint vp;
            int s;
            r = '{tlpa_pkg::STATUS_FAIL, '0};
            vp = addr >> tlpa_pkg::PAGE_OFFSET_BITS;
            if (vp >= tlpa_pkg::VPAGES || !dir_valid[vp >> tlpa_pkg::TABLE_INDEX_BITS])
                return r;
            s = slot_index(int'(vp));
            if (!slot_valid[s])
                return r;
            r.status = tlpa_pkg::STATUS_OK;
            r.address = AW'((longint'(slot_frame[s]) << tlpa_pkg::PAGE_OFFSET_BITS)
                            | (addr % tlpa_pkg::PG_BYTES));
            return r;
        endfunction

        function void note_request(logic [KW-1:0] kind, logic [AW-1:0] addr,
                                   logic [BW-1:0] bytes);
            response_t r;
            r = '{tlpa_pkg::STATUS_FAIL, '0};
            unique case (kind)
                tlpa_pkg::KIND_ALLOC:
                    r = allocate(bytes);
                tlpa_pkg::KIND_FREE:
                begin
                    release_range(addr, bytes);
                    r.status = tlpa_pkg::STATUS_OK;
                end
                tlpa_pkg::KIND_XLATE:
                    r = translate(addr);
                default:
                begin
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_response(response_t got);
            response_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected response %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.address !== want.address)
            begin
                $error("result_address: expected %h actual %h", want.address, got.address);
                errors++;
            end
        endfunction
    endclass

    logic          clk = 0;
    logic          rst_n = 0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [SW-1:0] s_axis_tdata = '0;
    logic [KW-1:0] s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [MW-1:0] m_axis_tdata;

    page_scoreboard board = new();
    longint cycles = 0;

    always #5 clk = ~clk;

    two_level_page_allocator_mmu dut (.*);

    // cycle limit: the run fails once the cycle counter passes CYCLE_LIMIT
    localparam longint CYCLE_LIMIT = 100_000_000;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one request transfer
    task automatic send_request(logic [KW-1:0] kind, logic [AW-1:0] addr,
                                logic [BW-1:0] bytes);
        int gap;
        gap = gap_length();
        repeat (gap + 1) @(negedge clk);
        s_axis_tuser <= kind;
        s_axis_tdata <= SW'({bytes, addr});
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(kind, addr, bytes);
        @(negedge clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // response side with random stalls
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = gap_length();
            m_axis_tready <= (stall == 0);
            if (stall != 0)
            begin
                repeat (stall) @(negedge clk);
                m_axis_tready <= 1;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_response(response_t'({m_axis_tdata[0], m_axis_tdata[AW:1]}));

    function logic [BW-1:0] random_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return BW'($urandom_range(1, 4 * tlpa_pkg::PG_BYTES));
        if (p < 85)
            return BW'($urandom_range(1, 24 * tlpa_pkg::PG_BYTES));
        if (p < 95)
            return BW'($urandom_range(0, 2**BW - 1));
        return BW'($urandom_range(0, 1) ? 0 : 2**20);
    endfunction

    // address in a random virtual page (its base or a random offset), else random
    function logic [AW-1:0] random_address();
        int vp;
        if ($urandom_range(0, 3) != 0)
        begin
            vp = $urandom_range(0, tlpa_pkg::VPAGES - 1);
            return AW'((vp << tlpa_pkg::PAGE_OFFSET_BITS) |
                       ($urandom_range(0, 1) ? 0 : $urandom_range(0, tlpa_pkg::PG_BYTES - 1)));
        end
        return AW'($urandom());
    endfunction

    initial
    begin
        int k;
        board.clear_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed part
        send_request(tlpa_pkg::KIND_ALLOC, '0, '0);
        send_request(tlpa_pkg::KIND_ALLOC, '0, BW'(1));
        send_request(tlpa_pkg::KIND_XLATE, 20'h01abc, '0);
        send_request(tlpa_pkg::KIND_XLATE, 20'hfffff, '0);
        send_request(tlpa_pkg::KIND_XLATE, 20'h00000, '0);
        send_request(tlpa_pkg::KIND_ALLOC, 20'hfffff, 21'h1fffff);
        send_request(tlpa_pkg::KIND_ALLOC, '0, 21'h100000);
        send_request(tlpa_pkg::KIND_ALLOC, '0, BW'(5 * tlpa_pkg::PG_BYTES + 1));
        send_request(tlpa_pkg::KIND_XLATE, 20'h02fff, '0);
        send_request(tlpa_pkg::KIND_FREE, '0, 21'd4096);
        send_request(tlpa_pkg::KIND_FREE, 20'h01000, '0);
        send_request(tlpa_pkg::KIND_FREE, 20'h03000, 21'd4096);
        send_request(tlpa_pkg::KIND_XLATE, 20'h03000, '0);
        send_request(tlpa_pkg::KIND_ALLOC, '0, 21'd4096);
        send_request(tlpa_pkg::KIND_UNUSED, 20'hfffff, 21'h1fffff);
        // exhaust frames then recover
        send_request(tlpa_pkg::KIND_ALLOC, '0, BW'(80 * tlpa_pkg::PG_BYTES));
        send_request(tlpa_pkg::KIND_ALLOC, '0, BW'(40 * tlpa_pkg::PG_BYTES));
        send_request(tlpa_pkg::KIND_XLATE, 20'h3f123, '0);
        send_request(tlpa_pkg::KIND_FREE, 20'hff000, 21'h1fffff);
        send_request(tlpa_pkg::KIND_FREE, 20'h01000, 21'h100000);
        send_request(tlpa_pkg::KIND_XLATE, 20'h01000, '0);
        drain();

        // random part
        for (int i = 0; i < 2000; i++)
        begin
            k = $urandom_range(0, 99);
            if (i == 1000)
                drain();
            if (k < 40)
                send_request(tlpa_pkg::KIND_ALLOC, AW'($urandom()), random_count());
            else if (k < 65)
                send_request(tlpa_pkg::KIND_FREE, random_address(), random_count());
            else if (k < 97)
                send_request(tlpa_pkg::KIND_XLATE, random_address(), BW'($urandom()));
            else
                send_request(tlpa_pkg::KIND_UNUSED, AW'($urandom()), BW'($urandom()));
        end
        drain();
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

[filelist.f]
rtl/tlpa_pkg.sv
rtl/two_level_page_allocator_mmu.sv
rtl/tlpa_checker.sv
bench/tb_top.sv
